// ===== rtl/gpio_edge_event_detector_top_assert.svh =====
// ----------------------------------------------------------------------------
// GPIO edge event detector assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GPIO_EDGE_EVENT_DETECTOR_TOP_ASSERT_SVH
`define GPIO_EDGE_EVENT_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define GEDD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gedd assertion failed");

// next-cycle implication
`define GEDD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gedd assertion failed");

`endif

// ===== rtl/gedd_pkg.sv =====
// ----------------------------------------------------------------------------
// GPIO edge event detector package
// Field widths, operation and register codes, lane control bundle.
// ----------------------------------------------------------------------------
package gedd_pkg;

    localparam int PIN_COUNT_DEFAULT = 32;
    localparam int STATUS_W          = 32;
    localparam int LEVEL_W           = 32;
    localparam int OP_W              = 2;
    localparam int INDEX_W           = 5;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 32;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RISING_ENABLE  = 2'd0,
        CFG_FALLING_ENABLE = 2'd1,
        CFG_IRQ_ENABLE     = 2'd2
    } cfg_index_t;

    // per-pin control for one accepted transaction
    typedef struct packed {
        logic tick;
        logic clear;
        logic level;
        logic rise_en;
        logic fall_en;
    } lane_ctrl_t;

endpackage

// ===== rtl/gpio_edge_event_detector_top.sv =====
// ----------------------------------------------------------------------------
// GPIO edge event detector
// Synchronous rising/falling edge events with sticky status for GPIO pins.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): operation, pin_levels, pin_index.
//   operation tick shifts pin_levels into each pin's two-sample history and
//   sets sticky event bits on low-high-high (rising enabled) or high-low-low
//   (falling enabled); query returns one pin's event bit; clear drops one bit.
//   Output channel (out_valid/out_ready): event_status, pin_event,
//   irq_pending, one result transaction per input transaction, in order.
//   The result is registered at the accept edge.
//   Throughput is one transaction per cycle while out_ready keeps up; one lane
//   per pin runs in parallel; the merge stage ends in a single output register.
//   When the receiver stalls, in_ready drops while a result is held, and
//   rises again in the cycle out_ready takes it.
//   Config channel (cfg_valid/cfg_ready) is always ready: index 0 rising
//   enable, 1 falling enable, 2 irq enable; other indexes are ignored.
//   Reset clears samples, event bits, enables and the output valid.
// ----------------------------------------------------------------------------
module gpio_edge_event_detector_top #(
    parameter int PIN_COUNT = gedd_pkg::PIN_COUNT_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [gedd_pkg::OP_W-1:0]            operation,
    input  logic [gedd_pkg::LEVEL_W-1:0]         pin_levels,
    input  logic [gedd_pkg::INDEX_W-1:0]         pin_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gedd_pkg::STATUS_W-1:0]        event_status,
    output logic                                 pin_event,
    output logic                                 irq_pending,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gedd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gedd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int LANES = (PIN_COUNT < gedd_pkg::STATUS_W) ? PIN_COUNT
                                                            : gedd_pkg::STATUS_W;

    logic [LANES-1:0] rise_en_reg;
    logic [LANES-1:0] fall_en_reg;
    logic             irq_en_reg;
    logic             accept;
    logic             is_tick;
    logic             is_clear;
    logic             is_query;
    logic [LANES-1:0] event_vec;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign is_tick   = accept && (operation == gedd_pkg::OP_TICK);
    assign is_clear  = accept && (operation == gedd_pkg::OP_CLEAR);
    assign is_query  = (operation == gedd_pkg::OP_QUERY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_en_reg <= '0;
            fall_en_reg <= '0;
            irq_en_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gedd_pkg::CFG_RISING_ENABLE:  rise_en_reg <= cfg_data[LANES-1:0];
                gedd_pkg::CFG_FALLING_ENABLE: fall_en_reg <= cfg_data[LANES-1:0];
                gedd_pkg::CFG_IRQ_ENABLE:     irq_en_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        gedd_pkg::lane_ctrl_t ctrl;

        assign ctrl.tick    = is_tick;
        assign ctrl.clear   = is_clear && (pin_index == gedd_pkg::INDEX_W'(i));
        assign ctrl.level   = pin_levels[i];
        assign ctrl.rise_en = rise_en_reg[i];
        assign ctrl.fall_en = fall_en_reg[i];

        gedd_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .event_next (event_vec[i])
        );
    end

    gedd_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .query        (is_query),
        .pin_index    (pin_index),
        .event_vec    (event_vec),
        .irq_enable   (irq_en_reg),
        .out_ready    (out_ready),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .event_status (event_status),
        .pin_event    (pin_event),
        .irq_pending  (irq_pending)
    );

endmodule

// ===== rtl/gedd_lane.sv =====
// ----------------------------------------------------------------------------
// GPIO edge event detector lane
// Two-deep sample history and sticky event bit for a single pin.
// ----------------------------------------------------------------------------
module gedd_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gedd_pkg::lane_ctrl_t  ctrl,
    output logic                  event_next
);

    logic last_reg;
    logic older_reg;
    logic event_reg;
    logic rise_hit;
    logic fall_hit;

    // low, high, high -> rise; high, low, low -> fall (oldest first)
    assign rise_hit = ~older_reg & last_reg & ctrl.level & ctrl.rise_en;
    assign fall_hit = older_reg & ~last_reg & ~ctrl.level & ctrl.fall_en;

    always_comb
    begin
        if (ctrl.clear)
        begin
            event_next = 1'b0;
        end
        else
        begin
            event_next = event_reg | (ctrl.tick & (rise_hit | fall_hit));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            older_reg <= 1'b0;
            event_reg <= 1'b0;
        end
        else
        begin
            event_reg <= event_next;
            if (ctrl.tick)
            begin
                older_reg <= last_reg;
                last_reg  <= ctrl.level;
            end
        end
    end

`include "gpio_edge_event_detector_top_assert.svh"

    `GEDD_ASSERT_NXT(a_clear_drops_event, ctrl.clear, !event_reg)

endmodule

// ===== rtl/gedd_merge.sv =====
// ----------------------------------------------------------------------------
// GPIO edge event detector merge stage
// Gathers lane event bits into the status word, pin select and interrupt,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module gedd_merge #(
    parameter int LANES = gedd_pkg::PIN_COUNT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              query,
    input  logic [gedd_pkg::INDEX_W-1:0]      pin_index,
    input  logic [LANES-1:0]                  event_vec,
    input  logic                              irq_enable,
    input  logic                              out_ready,
    output logic                              in_ready,
    output logic                              out_valid,
    output logic [gedd_pkg::STATUS_W-1:0]     event_status,
    output logic                              pin_event,
    output logic                              irq_pending
);

    localparam int SW = gedd_pkg::STATUS_W;

    logic          out_valid_reg;
    logic [SW-1:0] status_reg;
    logic          pin_event_reg;
    logic          irq_reg;
    logic [SW-1:0] status_full;

    // pins past the lane count read as zero
    assign status_full = SW'(event_vec);
    assign in_ready    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_full;
            pin_event_reg <= query & status_full[pin_index];
            irq_reg       <= irq_enable & (|event_vec);
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_status = status_reg;
    assign pin_event    = pin_event_reg;
    assign irq_pending  = irq_reg;

`include "gpio_edge_event_detector_top_assert.svh"

    `GEDD_ASSERT_IMP(a_no_accept_while_stalled, accept, !out_valid_reg || out_ready)
    `GEDD_ASSERT_IMP(a_irq_needs_event, out_valid_reg && irq_reg, status_reg != '0)
    `GEDD_ASSERT_IMP(a_pin_event_needs_event, out_valid_reg && pin_event_reg,
        status_reg != '0)

endmodule
